@@ src/variable_width_bit_packer_macros.svh @@
// assertion macros shared by the bit packer rtl
`ifndef VARIABLE_WIDTH_BIT_PACKER_MACROS_SVH
`define VARIABLE_WIDTH_BIT_PACKER_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define VWBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vwbp assertion failed");
// next-cycle implication
`define VWBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vwbp assertion failed");
`else
`define VWBP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VWBP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/vwbp_pkg.sv @@
// shared types and constants of the bit packer
package vwbp_pkg;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BAD_WIDTH = 3'd1,
    STAT_NEG       = 3'd2,
    STAT_NO_ROOM   = 3'd3,
    STAT_TOO_LARGE = 3'd4
  } status_e;

  // kind of result loaded into the output register
  typedef enum logic [1:0] {
    RES_BYTE  = 2'd0,
    RES_NONE  = 2'd1,
    RES_FLUSH = 2'd2,
    RES_ERROR = 2'd3
  } res_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_ONE   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  // request type codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_END   = 1'b1;

  // widths at which negative values may be packed
  localparam logic [5:0] W_BYTE = 6'd8;
  localparam logic [5:0] W_HALF = 6'd16;
  localparam logic [5:0] W_WORD = 6'd32;

  // capacity register reset value
  localparam logic [15:0] CAP_RESET = 16'd1024;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic merge;
    logic load_out;
    res_e kind;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic    end_req;
    status_e chk;
    logic    has_byte;
    logic    more_bytes;
    logic    slot_free;
  } dp_sts_t;

endpackage

@@ src/vwbp_ctrl.sv @@
// controller state machine of the bit packer
`include "variable_width_bit_packer_macros.svh"

module vwbp_ctrl
  import vwbp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o.load_in  = 1'b0;
    cmd_o.merge    = 1'b0;
    cmd_o.load_out = 1'b0;
    cmd_o.kind     = RES_NONE;
    in_stall_o     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.end_req || (sts_i.chk != STAT_OK)) begin
          state_d = ST_ONE;
        end else begin
          cmd_o.merge = 1'b1;
          state_d     = ST_EMIT;
        end
      end
      ST_ONE: begin
        cmd_o.kind = sts_i.end_req ? RES_FLUSH : RES_ERROR;
        if (sts_i.slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_EMIT: begin
        cmd_o.kind = sts_i.has_byte ? RES_BYTE : RES_NONE;
        if (sts_i.slot_free) begin
          cmd_o.load_out = 1'b1;
          if (!sts_i.has_byte || !sts_i.more_bytes) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // checks
  `VWBP_ASSERT_NXT(a_check_moves_on, clk_i, rst_ni, state_q == ST_CHECK,
    state_q == ST_ONE || state_q == ST_EMIT)
  `VWBP_ASSERT_NXT(a_last_byte_idle, clk_i, rst_ni,
    state_q == ST_EMIT && sts_i.slot_free && !sts_i.more_bytes, state_q == ST_IDLE)
  `VWBP_ASSERT_IMP(a_merge_only_ok, clk_i, rst_ni, cmd_o.merge,
    !sts_i.end_req && sts_i.chk == STAT_OK)

endmodule

@@ src/vwbp_datapath.sv @@
// datapath of the bit packer: checks, accumulator and output register
`include "variable_width_bit_packer_macros.svh"

module vwbp_datapath
  import vwbp_pkg::*;
#(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic               req_type_i,
  input  logic signed [31:0] field_value_i,
  input  logic [5:0]         field_width_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic               last_of_run_o,
  output logic [2:0]         status_o
);

  // count must hold the pending bits and the two-byte threshold
  localparam int PendW = MAX_FIELD_BITS + 7;
  localparam int CntW  = $clog2(MAX_FIELD_BITS + 9);
  localparam logic [5:0]      MaxW     = 6'(MAX_FIELD_BITS);
  localparam logic [CntW-1:0] OneByte  = CntW'(8);
  localparam logic [CntW-1:0] TwoBytes = CntW'(16);

  // captured request
  logic        req_q;
  logic [31:0] val_q;
  logic [5:0]  wid_q;

  // message state
  logic [PendW-1:0] pend_q, pend_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [15:0]      done_q, done_d;
  logic [15:0]      cap_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_bv_q, out_bv_d;
  logic        out_last_q, out_last_d;
  status_e     out_status_q, out_status_d;

  // check signals
  logic [31:0]      low_mask;
  logic             bad_width, neg_ok, no_room, too_large;
  logic [18:0]      used_bits;
  logic [19:0]      need_bits;
  status_e          chk;
  logic [PendW-1:0] field_bits;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      req_q <= req_type_i;
      val_q <= field_value_i;
      wid_q <= field_width_i;
    end
  end

  // write checks, first failing one wins
  always_comb begin
    low_mask  = 32'((33'd1 << wid_q) - 33'd1);
    bad_width = (wid_q == 6'd0) || (wid_q > MaxW);
    neg_ok    = (wid_q == W_BYTE) || (wid_q == W_HALF) || (wid_q == W_WORD);
    used_bits = {done_q, 3'b000} + 19'(cnt_q[2:0]);
    need_bits = 20'(used_bits) + 20'(wid_q);
    no_room   = need_bits > {1'b0, cap_q, 3'b000};
    too_large = (wid_q != W_WORD) &&
                (val_q[31] ? ((val_q | (low_mask >> 1)) != '1)
                           : ((val_q & ~low_mask) != '0));
    if (bad_width) begin
      chk = STAT_BAD_WIDTH;
    end else if (val_q[31] && !neg_ok) begin
      chk = STAT_NEG;
    end else if (no_room) begin
      chk = STAT_NO_ROOM;
    end else if (too_large) begin
      chk = STAT_TOO_LARGE;
    end else begin
      chk = STAT_OK;
    end
  end

  // accumulator update and result selection
  always_comb begin
    field_bits   = PendW'(val_q & low_mask);
    pend_d       = pend_q;
    cnt_d        = cnt_q;
    done_d       = done_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_byte_d   = out_byte_q;
    out_bv_d     = out_bv_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    if (cmd_i.merge) begin
      pend_d = pend_q | (field_bits << cnt_q[2:0]);
      cnt_d  = cnt_q + CntW'(wid_q);
    end
    if (cmd_i.load_out) begin
      out_valid_d  = 1'b1;
      out_byte_d   = 8'd0;
      out_bv_d     = 1'b0;
      out_last_d   = 1'b1;
      out_status_d = STAT_OK;
      case (cmd_i.kind)
        RES_BYTE: begin
          out_byte_d = pend_q[7:0];
          out_bv_d   = 1'b1;
          out_last_d = cnt_q < TwoBytes;
          pend_d     = pend_q >> 8;
          cnt_d      = cnt_q - OneByte;
          done_d     = done_q + 16'd1;
        end
        RES_FLUSH: begin
          if (cnt_q != '0) begin
            out_byte_d = pend_q[7:0];
            out_bv_d   = 1'b1;
          end
          pend_d = '0;
          cnt_d  = '0;
          done_d = '0;
        end
        RES_ERROR: begin
          out_status_d = chk;
        end
        default: begin
        end
      endcase
    end
  end

  // state and config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= '0;
      cnt_q       <= '0;
      done_q      <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    out_bv_q     <= out_bv_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  // status to controller
  always_comb begin
    sts_o.end_req    = (req_q == REQ_END);
    sts_o.chk        = chk;
    sts_o.has_byte   = cnt_q >= OneByte;
    sts_o.more_bytes = cnt_q >= TwoBytes;
    sts_o.slot_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign byte_valid_o  = out_bv_q;
  assign last_of_run_o = out_last_q;
  assign status_o      = out_status_q;

  // checks
  `VWBP_ASSERT_IMP(a_nobyte_is_last, clk_i, rst_ni, out_valid_q && !out_bv_q, out_last_q)
  `VWBP_ASSERT_IMP(a_error_no_byte, clk_i, rst_ni,
    out_valid_q && out_status_q != STAT_OK, !out_bv_q)
  `VWBP_ASSERT_NXT(a_flush_clears, clk_i, rst_ni,
    cmd_i.load_out && cmd_i.kind == RES_FLUSH, cnt_q == '0 && done_q == '0)

endmodule

@@ src/variable_width_bit_packer.sv @@
// bit packer top level: lsb-first packing of 1 to MAX_FIELD_BITS bit fields
// a taken request is captured, checked, then its results load from ONE or EMIT
// an item causes 1 to 4 results at 32-bit fields; the next waits until all load
// results leave one per cycle from the single output register unless stalled
// reset: async active low, clears message state, capacity returns to 1024
module variable_width_bit_packer
  import vwbp_pkg::*;
#(
  parameter int MAX_FIELD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic signed [31:0] field_value_i,
  input  logic [5:0]         field_width_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic               last_of_run_o,
  output logic [2:0]         status_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer
  vwbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // checks, accumulator and output register
  vwbp_datapath #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .field_value_i (field_value_i),
    .field_width_i (field_width_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_of_run_o (last_of_run_o),
    .status_o      (status_o)
  );

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the variable width bit packer with a built-in packing predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import vwbp_pkg::*;

  localparam int FIELD_BITS_MAX = 32;

  // one result as the packer should deliver it
  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       last;
    status_e    st;
  } byte_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               req_type_i = REQ_WRITE;
  logic signed [31:0] field_value_i = '0;
  logic [5:0]         field_width_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [15:0]        cfg_wdata_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         out_byte_o;
  logic               byte_valid_o;
  logic               last_of_run_o;
  logic [2:0]         status_o;

  // predictor state
  logic [15:0]  capacity = CAP_RESET;
  logic [38:0]  acc_bits = '0;
  int           acc_count = 0;
  logic [15:0]  msg_bytes = '0;
  byte_result_t expected_bytes[$];

  int mismatch_count = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  variable_width_bit_packer #(
    .MAX_FIELD_BITS(FIELD_BITS_MAX)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .field_value_i(field_value_i),
    .field_width_i(field_width_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_of_run_o(last_of_run_o),
    .status_o     (status_o)
  );

  always #6 clk_i = ~clk_i;

  // run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void push_result(logic [7:0] data, logic vld, logic last, status_e st);
    byte_result_t r;
    r.data = data;
    r.vld  = vld;
    r.last = last;
    r.st   = st;
    expected_bytes.push_back(r);
  endfunction

  // work out the results of one accepted request
  function automatic void predict_packed_bytes(logic rt, logic [31:0] raw, logic [5:0] w);
    longint  v;
    longint  used;
    status_e st;
    logic [38:0] mask;
    int nb;
    if (rt == REQ_END) begin
      if (acc_count > 0) push_result(acc_bits[7:0], 1'b1, 1'b1, STAT_OK);
      else push_result(8'd0, 1'b0, 1'b1, STAT_OK);
      acc_bits  = '0;
      acc_count = 0;
      msg_bytes = '0;
      return;
    end
    v = raw[31] ? longint'(raw) - 64'sh1_0000_0000 : longint'(raw);
    used = longint'(msg_bytes) * 8 + acc_count;
    // checks in priority order
    if (w == 0 || w > FIELD_BITS_MAX) st = STAT_BAD_WIDTH;
    else if (v < 0 && !(w == W_BYTE || w == W_HALF || w == W_WORD)) st = STAT_NEG;
    else if (longint'(w) + used > longint'(capacity) * 8) st = STAT_NO_ROOM;
    else if (w != W_WORD && v > 0 && v > (64'sd1 << w) - 1) st = STAT_TOO_LARGE;
    else if (w != W_WORD && v <= 0 && v < -(64'sd1 << (w - 1))) st = STAT_TOO_LARGE;
    else st = STAT_OK;
    if (st != STAT_OK) begin
      push_result(8'd0, 1'b0, 1'b1, st);
      return;
    end
    // append the field above the pending bits and emit whole bytes
    mask = (39'd1 << w) - 39'd1;
    acc_bits = acc_bits | ((39'(raw) & mask) << acc_count);
    acc_count = acc_count + int'(w);
    nb = acc_count / 8;
    if (nb == 0) push_result(8'd0, 1'b0, 1'b1, STAT_OK);
    for (int i = 0; i < nb; i++) begin
      push_result(acc_bits[7:0], 1'b1, (i == nb - 1), STAT_OK);
      acc_bits  = acc_bits >> 8;
      acc_count = acc_count - 8;
      msg_bytes = msg_bytes + 16'd1;
    end
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // monitor: register writes, accepted requests and accepted results
  always @(posedge clk_i) begin
    byte_result_t exp_r;
    if (rst_ni) begin
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (in_valid_i && !in_stall_o)
        predict_packed_bytes(req_type_i, field_value_i, field_width_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %0h valid %0b last %0b status %0d",
                   $time, out_byte_o, byte_valid_o, last_of_run_o, status_o);
          mismatch_count++;
        end else begin
          exp_r = expected_bytes.pop_front();
          check_field("out_byte", exp_r.data, out_byte_o);
          check_field("byte_valid", 8'(exp_r.vld), 8'(byte_valid_o));
          check_field("last_of_run", 8'(exp_r.last), 8'(last_of_run_o));
          check_field("status", 8'(exp_r.st), 8'(status_o));
        end
      end
    end
  end

  // receiver stalls in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    out_stall_i <= (stall_left > 0);
  end

  // send one request and wait until it is taken
  task automatic send_request(logic rt, logic [31:0] val, logic [5:0] w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= rt;
    field_value_i <= val;
    field_width_i <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // hold off requests until every expected result has come
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_bytes.size() != 0);
  endtask

  task automatic write_capacity(logic [15:0] value);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_end();
    send_request(REQ_END, $urandom, 6'($urandom_range(0, 63)));
  endtask

  // well-formed write, now and then just past a range limit
  task automatic send_legal_field();
    logic [5:0]  w;
    logic [31:0] v;
    w = 6'($urandom_range(1, 32));
    v = $urandom;
    if (w != W_WORD) begin
      v = v & ((32'd1 << w) - 32'd1);
      if ((w == W_BYTE || w == W_HALF) && $urandom_range(0, 1) == 1)
        v = -32'($urandom_range(1, 1 << (w - 1)));
      case ($urandom_range(0, 11))
        0: v = 32'd1 << w;
        1: if (w == W_BYTE || w == W_HALF) v = -((32'd1 << (w - 1)) + 32'd1);
        default: ;
      endcase
    end
    send_request(REQ_WRITE, v, w);
  endtask

  // field extremes, flush with and without pending bits
  task automatic test_field_extremes();
    send_end();
    send_request(REQ_WRITE, 32'd1, 6'd1);
    send_request(REQ_WRITE, 32'hffff_ffff, W_WORD);
    send_end();
    send_request(REQ_WRITE, 32'h7fff_ffff, 6'd31);
    send_request(REQ_WRITE, -32'sd128, W_BYTE);
    send_request(REQ_WRITE, -32'sd32768, W_HALF);
    send_request(REQ_WRITE, 32'h8000_0000, W_WORD);
    send_end();
  endtask

  // each rejection but no room, and the order of the checks
  task automatic test_rejections();
    send_request(REQ_WRITE, 32'd5, 6'd0);
    send_request(REQ_WRITE, 32'd5, 6'd33);
    send_request(REQ_WRITE, 32'hffff_ffff, 6'd63);
    send_request(REQ_WRITE, 32'hffff_ffff, 6'd7);
    send_request(REQ_WRITE, 32'd16, 6'd4);
    send_request(REQ_WRITE, -32'sd129, W_BYTE);
    send_request(REQ_WRITE, 32'd65536, W_HALF);
    send_request(REQ_WRITE, 32'd0, 6'd1);
    send_end();
  endtask

  // capacity limits, including a capacity lowered under the bytes already used
  task automatic test_capacity();
    write_capacity(16'd0);
    send_request(REQ_WRITE, 32'd16, 6'd4);
    send_end();
    write_capacity(16'd2);
    send_request(REQ_WRITE, 32'h0000_abcd, W_HALF);
    send_request(REQ_WRITE, 32'd1, 6'd1);
    send_end();
    write_capacity(16'hffff);
    send_request(REQ_WRITE, $urandom & 32'h00ff_ffff, 6'd24);
    write_capacity(16'd1);
    send_request(REQ_WRITE, 32'd1, 6'd1);
    send_end();
  endtask

  // random messages of mostly legal fields with some noise
  task automatic test_random_messages(int count);
    int sent;
    int nfields;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 4))
          0: write_capacity(16'd0);
          1: write_capacity(16'hffff);
          2: write_capacity(16'($urandom));
          default: write_capacity(16'($urandom_range(1, 12)));
        endcase
      end
      idle_on = ($urandom_range(0, 3) != 0);
      nfields = $urandom_range(1, 12);
      for (int i = 0; i < nfields; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_request(1'($urandom), $urandom, 6'($urandom_range(0, 63)));
        else
          send_legal_field();
        sent++;
      end
      if ($urandom_range(0, 7) != 0) begin
        send_end();
        sent++;
      end
    end
    idle_on = 1'b1;
  endtask

  // closing stretch at full rate on both sides
  task automatic test_steady_stream(int count);
    write_capacity(16'hffff);
    idle_on = 1'b0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) send_end();
      else send_legal_field();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_rejections();
    test_capacity();
    test_random_messages(260);
    test_steady_stream(40);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (expected_bytes.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, expected_bytes.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ variable_width_bit_packer.f @@
+incdir+src
src/vwbp_pkg.sv
src/vwbp_ctrl.sv
src/vwbp_datapath.sv
src/variable_width_bit_packer.sv
tb/sv/testbench.sv
